// File: rtl/core/vcsc_pkg.sv
// Shared types, codes and reset tables for the vending credit and stock controller.
package vcsc_pkg;

  // Fixed field and register widths.
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned COIN_W      = 2;
  localparam int unsigned PROD_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PRICE_W     = 7;
  localparam int unsigned CREDIT_W    = 8;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned STOCK_W     = 4;
  localparam int unsigned COIN_VAL_W  = 4;
  localparam int unsigned MASK_W      = 5;
  localparam int unsigned NUM_PRICES  = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = PRICE_W;

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_COIN     = 3'd0,
    CMD_PRESS    = 3'd1,
    CMD_RETURN   = 3'd2,
    CMD_REFILL   = 3'd3,
    CMD_WITHDRAW = 3'd4
  } cmd_e;

  // Status codes of a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FUNDS = 2'd1,
    STAT_SOLD_OUT = 2'd2,
    STAT_COIN_REJ = 2'd3
  } status_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

  // Dollar value of each coin kind.
  function automatic logic [COIN_VAL_W-1:0] coin_value(logic [COIN_W-1:0] code);
    logic [COIN_VAL_W-1:0] val;
    case (code)
      2'd0:    val = 4'd1;
      2'd1:    val = 4'd2;
      2'd2:    val = 4'd5;
      default: val = 4'd10;
    endcase
    return val;
  endfunction

  // Price after reset; products past the register list cost nothing.
  function automatic logic [PRICE_W-1:0] price_reset(int unsigned p);
    logic [PRICE_W-1:0] val;
    case (p)
      0:       val = 7'd10;
      1:       val = 7'd6;
      2:       val = 7'd5;
      3:       val = 7'd8;
      4:       val = 7'd7;
      default: val = 7'd0;
    endcase
    return val;
  endfunction

  // Stock after reset; extra products start empty.
  function automatic logic [STOCK_W-1:0] stock_reset(int unsigned p);
    logic [STOCK_W-1:0] val;
    case (p)
      0:       val = 4'd5;
      1:       val = 4'd1;
      2:       val = 4'd2;
      3:       val = 4'd1;
      4:       val = 4'd9;
      default: val = 4'd0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/vcsc_ctrl.sv
// Handshake controller: tracks the result register and issues execute commands.
module vcsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vcsc_pkg::ctrl_cmd_t   cmd_o
);
  import vcsc_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic exec;

  // A new transaction may enter whenever the result register is free or is being drained.
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_FULL);
  assign cmd_o.exec  = exec;

  // Next state of the result register occupancy.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (exec) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (exec) state_d = ST_FULL;
        else if (out_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/vcsc_dp.sv
// Datapath: price registers, credit, cash, revenue, stock and the result register.
module vcsc_dp #(
  parameter int unsigned NUM_PRODUCTS = 5,
  parameter int unsigned CREDIT_MAX   = 255,
  parameter int unsigned FULL_LEVEL   = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vcsc_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                cfg_we_i,
  input  logic [vcsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vcsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [vcsc_pkg::CMD_W-1:0]          command_i,
  input  logic [vcsc_pkg::COIN_W-1:0]         coin_code_i,
  input  logic [vcsc_pkg::PROD_W-1:0]         product_i,
  output logic [vcsc_pkg::STATUS_W-1:0]       status_o,
  output logic                                dispensed_o,
  output logic [vcsc_pkg::CNT_W-1:0]          paid_out_o,
  output logic [vcsc_pkg::CREDIT_W-1:0]       credit_now_o,
  output logic [vcsc_pkg::CNT_W-1:0]          revenue_now_o,
  output logic [vcsc_pkg::MASK_W-1:0]         available_mask_o,
  output logic [vcsc_pkg::MASK_W-1:0]         sold_out_mask_o
);
  import vcsc_pkg::*;

  localparam logic [CNT_W-1:0] CntMax = {CNT_W{1'b1}};

  logic [PRICE_W-1:0]  price_q [NUM_PRICES];
  logic [PRICE_W-1:0]  lane_price [NUM_PRODUCTS];
  logic [STOCK_W-1:0]  stock_q [NUM_PRODUCTS];
  logic [STOCK_W-1:0]  stock_d [NUM_PRODUCTS];
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic [CNT_W-1:0]    cash_q, cash_d;
  logic [CNT_W-1:0]    rev_q, rev_d;

  logic [NUM_PRODUCTS-1:0] sel;
  logic                    prod_ok;
  logic [STOCK_W-1:0]      cur_stock;
  logic [PRICE_W-1:0]      cur_price;
  logic [COIN_VAL_W-1:0]   coin_val;
  logic [CREDIT_W:0]       credit_sum;
  logic [CNT_W:0]          cash_sum;
  logic [CNT_W:0]          rev_sum;
  logic [STATUS_W-1:0]     status_d;
  logic                    disp_d;
  logic [CNT_W-1:0]        paid_d;
  logic [MASK_W-1:0]       avail_d;
  logic [MASK_W-1:0]       sold_d;

  // Per-product price lanes and result mask bits.
  for (genvar p = 0; p < NUM_PRODUCTS; p++) begin : g_lane
    if (p < NUM_PRICES) begin : g_priced
      assign lane_price[p] = price_q[p];
    end else begin : g_free
      assign lane_price[p] = '0;
    end
  end

  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < NUM_PRODUCTS) begin : g_used
      assign sold_d[m]  = (stock_d[m] == '0);
      assign avail_d[m] = (stock_d[m] != '0) && (credit_d >= {1'b0, lane_price[m]});
    end else begin : g_unused
      assign sold_d[m]  = 1'b0;
      assign avail_d[m] = 1'b0;
    end
  end

  // Product selection: one-hot lane select and the selected stock and price.
  always_comb begin
    prod_ok   = (int'(product_i) < NUM_PRODUCTS);
    cur_stock = '0;
    cur_price = '0;
    for (int p = 0; p < NUM_PRODUCTS; p++) begin
      sel[p] = prod_ok && (product_i == PROD_W'(p));
      if (sel[p]) begin
        cur_stock = cur_stock | stock_q[p];
        cur_price = cur_price | lane_price[p];
      end
    end
  end

  // Command execution: next bookkeeping state and result fields.
  always_comb begin
    coin_val   = coin_value(coin_code_i);
    credit_sum = {1'b0, credit_q} + (CREDIT_W + 1)'(coin_val);
    cash_sum   = {1'b0, cash_q} + (CNT_W + 1)'(coin_val);
    rev_sum    = {1'b0, rev_q} + (CNT_W + 1)'(cur_price);

    credit_d = credit_q;
    cash_d   = cash_q;
    rev_d    = rev_q;
    for (int p = 0; p < NUM_PRODUCTS; p++) stock_d[p] = stock_q[p];
    status_d = STAT_OK;
    disp_d   = 1'b0;
    paid_d   = '0;

    case (cmd_e'(command_i))
      CMD_COIN: begin
        if (credit_sum > (CREDIT_W + 1)'(CREDIT_MAX)) begin
          status_d = STAT_COIN_REJ;
        end else begin
          credit_d = credit_sum[CREDIT_W-1:0];
          cash_d   = cash_sum[CNT_W] ? CntMax : cash_sum[CNT_W-1:0];
        end
      end
      CMD_PRESS: begin
        if (prod_ok) begin
          if (cur_stock == '0) begin
            status_d = STAT_SOLD_OUT;
          end else if (credit_q < {1'b0, cur_price}) begin
            status_d = STAT_NO_FUNDS;
          end else begin
            credit_d = credit_q - {1'b0, cur_price};
            rev_d    = rev_sum[CNT_W] ? CntMax : rev_sum[CNT_W-1:0];
            disp_d   = 1'b1;
            for (int p = 0; p < NUM_PRODUCTS; p++) begin
              if (sel[p]) stock_d[p] = stock_q[p] - STOCK_W'(1);
            end
          end
        end
      end
      CMD_RETURN: begin
        paid_d   = CNT_W'(credit_q);
        cash_d   = (cash_q >= CNT_W'(credit_q)) ? cash_q - CNT_W'(credit_q) : '0;
        credit_d = '0;
      end
      CMD_REFILL: begin
        for (int p = 0; p < NUM_PRODUCTS; p++) begin
          if (sel[p]) stock_d[p] = STOCK_W'(FULL_LEVEL);
        end
      end
      CMD_WITHDRAW: begin
        paid_d   = cash_q;
        cash_d   = '0;
        credit_d = '0;
        rev_d    = '0;
      end
      default: begin
      end
    endcase
  end

  // Bookkeeping registers and price registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      cash_q   <= '0;
      rev_q    <= '0;
      for (int p = 0; p < NUM_PRODUCTS; p++) stock_q[p] <= stock_reset(p);
      for (int r = 0; r < NUM_PRICES; r++) price_q[r] <= price_reset(r);
    end else begin
      if (cmd_i.exec) begin
        credit_q <= credit_d;
        cash_q   <= cash_d;
        rev_q    <= rev_d;
        for (int p = 0; p < NUM_PRODUCTS; p++) stock_q[p] <= stock_d[p];
      end
      if (cfg_we_i && (int'(cfg_index_i) < NUM_PRICES)) begin
        price_q[cfg_index_i] <= cfg_wdata_i;
      end
    end
  end

  // Result register, loaded with each executed transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o         <= status_d;
      dispensed_o      <= disp_d;
      paid_out_o       <= paid_d;
      credit_now_o     <= credit_d;
      revenue_now_o    <= rev_d;
      available_mask_o <= avail_d;
      sold_out_mask_o  <= sold_d;
    end
  end

endmodule

// File: rtl/core/vending_credit_stock_controller.sv
// Top level of the vending credit and stock controller.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   command_i, coin_code_i, product_i
//   out       output     out_valid_o / out_ready_i status_o, dispensed_o, paid_out_o,
//                                                  credit_now_o, revenue_now_o,
//                                                  available_mask_o, sold_out_mask_o
//   cfg       input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Each command executes in the cycle it is accepted and its result appears in the
// output register on the next cycle, so one transaction per cycle is sustained while
// results are taken (out_ready_i high). The single result register holds each result.
// A stalled result holds the input off only while out_ready_i is low.
// Reset restores prices, stock, credit, cash and revenue at once; no clearing pass.
module vending_credit_stock_controller #(
  parameter int unsigned NUM_PRODUCTS = 5,
  parameter int unsigned CREDIT_MAX   = 255,
  parameter int unsigned FULL_LEVEL   = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vcsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vcsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vcsc_pkg::CMD_W-1:0]          command_i,
  input  logic [vcsc_pkg::COIN_W-1:0]         coin_code_i,
  input  logic [vcsc_pkg::PROD_W-1:0]         product_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vcsc_pkg::STATUS_W-1:0]       status_o,
  output logic                                dispensed_o,
  output logic [vcsc_pkg::CNT_W-1:0]          paid_out_o,
  output logic [vcsc_pkg::CREDIT_W-1:0]       credit_now_o,
  output logic [vcsc_pkg::CNT_W-1:0]          revenue_now_o,
  output logic [vcsc_pkg::MASK_W-1:0]         available_mask_o,
  output logic [vcsc_pkg::MASK_W-1:0]         sold_out_mask_o
);
  import vcsc_pkg::*;

  ctrl_cmd_t cmd;

  // Controller for the transaction handshake.
  vcsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Bookkeeping datapath.
  vcsc_dp #(
    .NUM_PRODUCTS (NUM_PRODUCTS),
    .CREDIT_MAX   (CREDIT_MAX),
    .FULL_LEVEL   (FULL_LEVEL)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .coin_code_i      (coin_code_i),
    .product_i        (product_i),
    .status_o         (status_o),
    .dispensed_o      (dispensed_o),
    .paid_out_o       (paid_out_o),
    .credit_now_o     (credit_now_o),
    .revenue_now_o    (revenue_now_o),
    .available_mask_o (available_mask_o),
    .sold_out_mask_o  (sold_out_mask_o)
  );

  // The input is held off only by a pending result that is not being taken.
  a_ready_only_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // A dispensed product always reports an ok status.
  a_dispense_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dispensed_o) |-> (status_o == STAT_OK))
    else $error("dispensed with a failing status");

  // A product is never both available and sold out.
  a_masks_disjoint : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((available_mask_o & sold_out_mask_o) == '0))
    else $error("available and sold-out masks overlap");

  // Credit never exceeds its limit.
  a_credit_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(credit_now_o) <= CREDIT_MAX))
    else $error("credit above its limit");

endmodule
